// ----- design/qat_pkg.sv -----
// ----------------------------------------------------------------------------
// qat_pkg: quoted argument tokenizer package
// Result word type, mode and code constants, escape mapping.
// ----------------------------------------------------------------------------
package qat_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_ARG_END   = 2'd1,
        KIND_LINE_DONE = 2'd2
    } kind_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ESCAPE   = 2'd1;
    localparam logic [1:0] STATUS_UNCLOSED = 2'd2;

    typedef enum logic [3:0] {
        MODE_TOP      = 4'b0001,
        MODE_DQ       = 4'b0010,
        MODE_SQ       = 4'b0100,
        MODE_SQ_IN_DQ = 4'b1000
    } mode_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic [1:0] line_status;
        logic       last;
    } result_t;

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        begin
            r = c;
            if (c == CH_LOW_T)
            begin
                r = CH_TAB;
            end
            else if (c == CH_LOW_R)
            begin
                r = CH_CR;
            end
            else if (c == CH_LOW_N)
            begin
                r = CH_LF;
            end
            return r;
        end
    endfunction

endpackage

// ----- design/quoted_argument_tokenizer.sv -----
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer
// Splits command-line bytes into arguments with quotes and backslash escapes.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  item     | item_valid / item_ready    | ch, end_of_line
//  result   | result_valid / result_ready| kind, out_byte, line_status, last
//
//  One item accepted per cycle while item_ready; its 0..2 result words are
//  written to a 4-entry result queue in the same cycle; one leaves per ready cycle.
//  A terminator after a non-empty argument adds two words, so the queue
//  drains one word behind such a line.
//  item_ready is high while the queue has room for two words.
//  Reset (rst_n, async) clears tokenizer state and empties the queue.
// ----------------------------------------------------------------------------
module quoted_argument_tokenizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [7:0]          ch,
    input  logic                end_of_line,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [1:0]          kind,
    output logic [7:0]          out_byte,
    output logic [1:0]          line_status,
    output logic                last
);
    import qat_pkg::*;

    mode_t            mode_reg, mode_next;
    logic             esc_reg, esc_next;
    logic             has_reg, has_next;

    result_t          fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    result_t          res0, res1;
    logic [1:0]       push_n;
    logic             emit;
    logic [7:0]       emit_byte;
    logic [1:0]       status;
    logic             push, pop;
    result_t          head;

    assign item_ready = (cnt_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign push       = item_valid && item_ready;
    assign pop        = result_valid && result_ready;

    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        has_next  = has_reg;
        emit      = 1'b0;
        emit_byte = ch;
        push_n    = 2'd0;
        res0      = '{kind: KIND_BYTE, out_byte: 8'd0, line_status: STATUS_OK, last: 1'b1};
        res1      = '{kind: KIND_LINE_DONE, out_byte: 8'd0, line_status: STATUS_OK,
                      last: 1'b1};
        status    = STATUS_OK;

        if (esc_reg)
        begin
            status = STATUS_ESCAPE;
        end
        else if (mode_reg != MODE_TOP)
        begin
            status = STATUS_UNCLOSED;
        end

        if (end_of_line)
        begin
            res1.line_status = status;
            if (has_reg)
            begin
                res0.kind = KIND_ARG_END;
                res0.last = 1'b0;
                push_n    = 2'd2;
            end
            else
            begin
                res0   = res1;
                push_n = 2'd1;
            end
            mode_next = MODE_TOP;
            esc_next  = 1'b0;
            has_next  = 1'b0;
        end
        else if (esc_reg)
        begin
            esc_next  = 1'b0;
            emit_byte = unescape(ch);
            emit      = 1'b1;
        end
        else if (ch == CH_BSLASH)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                MODE_TOP:
                begin
                    if (ch == CH_DQUOTE)
                    begin
                        mode_next = MODE_DQ;
                    end
                    else if (ch == CH_SQUOTE)
                    begin
                        mode_next = MODE_SQ;
                    end
                    else if (ch == CH_SPACE || ch == CH_TAB)
                    begin
                        if (has_reg)
                        begin
                            res0.kind = KIND_ARG_END;
                            push_n    = 2'd1;
                            has_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                MODE_DQ:
                begin
                    if (ch == CH_SQUOTE)
                    begin
                        mode_next = MODE_SQ_IN_DQ;
                    end
                    else if (ch == CH_DQUOTE)
                    begin
                        mode_next = MODE_TOP;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                MODE_SQ:
                begin
                    if (ch == CH_SQUOTE)
                    begin
                        mode_next = MODE_TOP;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                MODE_SQ_IN_DQ:
                begin
                    if (ch == CH_SQUOTE)
                    begin
                        mode_next = MODE_DQ;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_TOP;
                end
            endcase
        end

        if (emit)
        begin
            res0.kind     = KIND_BYTE;
            res0.out_byte = emit_byte;
            push_n        = 2'd1;
            has_next      = 1'b1;
        end

        if (!push)
        begin
            push_n    = 2'd0;
            mode_next = mode_reg;
            esc_next  = esc_reg;
            has_next  = has_reg;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_TOP;
            esc_reg    <= 1'b0;
            has_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            esc_reg    <= esc_next;
            has_reg    <= has_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            fifo_reg[PTR_W'(wr_ptr_reg + 1'b1)] <= res1;
        end
    end

    assign head         = fifo_reg[rd_ptr_reg];
    assign result_valid = (cnt_reg != '0);
    assign kind         = head.kind;
    assign out_byte     = head.out_byte;
    assign line_status  = head.line_status;
    assign last         = head.last;

endmodule

// ----- design/qat_checker.sv -----
// ----------------------------------------------------------------------------
// qat_checker
// Port-level checks for the quoted argument tokenizer.
// ----------------------------------------------------------------------------
module qat_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [1:0] kind,
    input logic [7:0] out_byte,
    input logic [1:0] line_status,
    input logic       last
);
    import qat_pkg::*;

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(kind)
            && $stable(out_byte) && $stable(line_status) && $stable(last))
        else $error("result word changed while stalled");

    // input only backs up when results are waiting
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
        else $error("item_ready low with empty result queue");

    // end of argument before line done: the done word is already queued
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && kind == KIND_ARG_END && !last
            |=> result_valid && kind == KIND_LINE_DONE && last)
        else $error("line done word missing after argument end");

    // line done always ends the words of its item; no unused code
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> kind != 2'd3 && (kind != KIND_LINE_DONE || last))
        else $error("bad result kind or last flag");

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .out_byte     (out_byte),
    .line_status  (line_status),
    .last         (last)
);

// ----- dv/quoted_argument_tokenizer_tb.sv -----
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_tb: self-checking bench for the argument tokenizer
// Drives a short table of directed bytes and terminators, then random command
// lines built from words, quoted spans, escapes and blanks plus some noise.
// Table rows give their own expected words, an in-bench model the rest; the
// monitor checks each accepted word by field under several idle/stall mixes.
// ----------------------------------------------------------------------------
module quoted_argument_tokenizer_tb;

    import qat_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 40;

    typedef struct {
        logic [7:0] c;
        logic       eol;
        int         n;
        result_t    r0;
        result_t    r1;
    } row_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic       item_ready;
    logic [7:0] ch           = 8'h00;
    logic       end_of_line  = 1'b0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] line_status;
    logic       last;

    row_t       stim_rows[$];
    result_t    token_words[$];
    result_t    seen_word;

    mode_t      tok_mode   = MODE_TOP;
    bit         tok_esc    = 1'b0;
    bit         tok_in_arg = 1'b0;

    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;
    int         items_in     = 0;
    int         err_cnt      = 0;
    int         cycle_cnt    = 0;
    int         hold_left    = 0;
    bit         hold_done    = 1'b0;

    quoted_argument_tokenizer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .ch           (ch),
        .end_of_line  (end_of_line),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .out_byte     (out_byte),
        .line_status  (line_status),
        .last         (last)
    );

    function automatic result_t mk_word(kind_t k, logic [7:0] b, logic [1:0] s, logic l);
        result_t w;
        begin
            w.kind        = k;
            w.out_byte    = b;
            w.line_status = s;
            w.last        = l;
            return w;
        end
    endfunction

    // Advance the tokenizer model by one item; optionally queue its words.
    function automatic void tokenize_byte(logic [7:0] c, logic eol, bit publish);
        result_t    w[2];
        int         n;
        bit         emit;
        logic [7:0] b;
        logic [1:0] status;
        begin
            n    = 0;
            emit = 1'b0;
            b    = c;
            if (eol)
            begin
                status = STATUS_OK;
                if (tok_esc)
                begin
                    status = STATUS_ESCAPE;
                end
                else if (tok_mode != MODE_TOP)
                begin
                    status = STATUS_UNCLOSED;
                end
                if (tok_in_arg)
                begin
                    w[n] = mk_word(KIND_ARG_END, 8'h00, STATUS_OK, 1'b0);
                    n++;
                end
                w[n] = mk_word(KIND_LINE_DONE, 8'h00, status, 1'b0);
                n++;
                tok_mode   = MODE_TOP;
                tok_esc    = 1'b0;
                tok_in_arg = 1'b0;
            end
            else if (tok_esc)
            begin
                tok_esc = 1'b0;
                case (c)
                    CH_LOW_T: b = CH_TAB;
                    CH_LOW_R: b = CH_CR;
                    CH_LOW_N: b = CH_LF;
                    default:  b = c;
                endcase
                emit = 1'b1;
            end
            else if (c == CH_BSLASH)
            begin
                tok_esc = 1'b1;
            end
            else
            begin
                case (tok_mode)
                    MODE_TOP:
                    begin
                        if (c == CH_DQUOTE)
                        begin
                            tok_mode = MODE_DQ;
                        end
                        else if (c == CH_SQUOTE)
                        begin
                            tok_mode = MODE_SQ;
                        end
                        else if (c == CH_SPACE || c == CH_TAB)
                        begin
                            if (tok_in_arg)
                            begin
                                w[n] = mk_word(KIND_ARG_END, 8'h00, STATUS_OK, 1'b0);
                                n++;
                                tok_in_arg = 1'b0;
                            end
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    MODE_DQ:
                    begin
                        if (c == CH_SQUOTE)
                        begin
                            tok_mode = MODE_SQ_IN_DQ;
                        end
                        else if (c == CH_DQUOTE)
                        begin
                            tok_mode = MODE_TOP;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    MODE_SQ:
                    begin
                        if (c == CH_SQUOTE)
                        begin
                            tok_mode = MODE_TOP;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (c == CH_SQUOTE)
                        begin
                            tok_mode = MODE_DQ;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                endcase
            end
            if (emit)
            begin
                w[n] = mk_word(KIND_BYTE, b, STATUS_OK, 1'b0);
                n++;
                tok_in_arg = 1'b1;
            end
            if (n > 0)
            begin
                w[n-1].last = 1'b1;
            end
            if (publish)
            begin
                for (int i = 0; i < n; i++)
                begin
                    token_words = {token_words, w[i]};
                end
            end
        end
    endfunction

    function automatic void add_row(logic [7:0] c, logic eol, int n, result_t r0, result_t r1);
        row_t r;
        begin
            r.c   = c;
            r.eol = eol;
            r.n   = n;
            r.r0  = r0;
            r.r1  = r1;
            stim_rows = {stim_rows, r};
        end
    endfunction

    function automatic void push_ch(logic [7:0] c);
        add_row(c, 1'b0, -1, '0, '0);
    endfunction

    function automatic logic [7:0] blank_byte();
        return ($urandom_range(1) == 0) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        begin
            if ($urandom_range(3) == 0)
            begin
                b = 8'($urandom_range(255));
                if (b == CH_SPACE || b == CH_TAB || b == CH_DQUOTE ||
                    b == CH_SQUOTE || b == CH_BSLASH)
                begin
                    b = 8'h78;
                end
            end
            else
            begin
                b = 8'h61 + 8'($urandom_range(25));
            end
            return b;
        end
    endfunction

    function automatic logic [7:0] esc_byte();
        case ($urandom_range(7))
            0:       return CH_LOW_T;
            1:       return CH_LOW_R;
            2:       return CH_LOW_N;
            3:       return CH_BSLASH;
            4:       return CH_DQUOTE;
            5:       return CH_SQUOTE;
            6:       return CH_SPACE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Span body without quotes; blanks and escapes mixed in.
    function automatic void add_span_body(int len);
        begin
            for (int k = 0; k < len; k++)
            begin
                case ($urandom_range(6))
                    0:       push_ch(blank_byte());
                    1:
                    begin
                        push_ch(CH_BSLASH);
                        push_ch(esc_byte());
                    end
                    default: push_ch(plain_byte());
                endcase
            end
        end
    endfunction

    // One command line; mostly well formed, some noise and broken tails.
    function automatic void add_line();
        int ntok;
        int tail;
        begin
            ntok = $urandom_range(5);
            for (int t = 0; t < ntok; t++)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3:
                    begin
                        for (int k = $urandom_range(1, 4); k > 0; k--)
                        begin
                            push_ch(plain_byte());
                        end
                    end
                    4:
                    begin
                        push_ch(CH_DQUOTE);
                        add_span_body($urandom_range(4));
                        if ($urandom_range(2) == 0)
                        begin
                            push_ch(CH_SQUOTE);
                            add_span_body($urandom_range(3));
                            if ($urandom_range(1) == 0)
                            begin
                                push_ch(CH_DQUOTE);
                            end
                            push_ch(CH_SQUOTE);
                        end
                        add_span_body($urandom_range(3));
                        push_ch(CH_DQUOTE);
                    end
                    5:
                    begin
                        push_ch(CH_SQUOTE);
                        add_span_body($urandom_range(4));
                        if ($urandom_range(3) == 0)
                        begin
                            push_ch(CH_DQUOTE);
                        end
                        push_ch(CH_SQUOTE);
                    end
                    6:
                    begin
                        push_ch(CH_BSLASH);
                        push_ch(esc_byte());
                    end
                    7:
                    begin
                        for (int k = $urandom_range(1, 3); k > 0; k--)
                        begin
                            push_ch(blank_byte());
                        end
                    end
                    8:
                    begin
                        if ($urandom_range(1) == 0)
                        begin
                            push_ch(CH_DQUOTE);
                            push_ch(CH_DQUOTE);
                        end
                        else
                        begin
                            push_ch(CH_SQUOTE);
                            push_ch(CH_SQUOTE);
                        end
                    end
                    default: push_ch(8'($urandom_range(255)));
                endcase
                if ($urandom_range(2) == 0)
                begin
                    push_ch(blank_byte());
                end
            end
            tail = $urandom_range(99);
            if (tail < 8)
            begin
                push_ch(CH_BSLASH);
            end
            else if (tail < 15)
            begin
                push_ch(($urandom_range(1) == 0) ? CH_DQUOTE : CH_SQUOTE);
            end
            add_row(8'($urandom_range(255)), 1'b1, -1, '0, '0);
        end
    endfunction

    task automatic drive_row(row_t r);
        begin
            while ($urandom_range(99) < src_idle_pct)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
            item_valid  <= 1'b1;
            ch          <= r.c;
            end_of_line <= r.eol;
            @(posedge clk);
            while (!item_ready)
            begin
                @(posedge clk);
            end
            tokenize_byte(r.c, r.eol, r.n < 0);
            if (r.n >= 1)
            begin
                token_words = {token_words, r.r0};
            end
            if (r.n >= 2)
            begin
                token_words = {token_words, r.r1};
            end
            items_in++;
        end
    endtask

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (!hold_done && items_in >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (token_words.size() == 0)
            begin
                $error("unexpected word: kind %0d out_byte %0h line_status %0d last %0d",
                       kind, out_byte, line_status, last);
                err_cnt++;
            end
            else
            begin
                seen_word = token_words[0];
                token_words.delete(0);
                if (kind !== seen_word.kind)
                begin
                    $error("kind: expected %0d actual %0d", seen_word.kind, kind);
                    err_cnt++;
                end
                if (out_byte !== seen_word.out_byte)
                begin
                    $error("out_byte: expected %0h actual %0h", seen_word.out_byte, out_byte);
                    err_cnt++;
                end
                if (line_status !== seen_word.line_status)
                begin
                    $error("line_status: expected %0d actual %0d",
                           seen_word.line_status, line_status);
                    err_cnt++;
                end
                if (last !== seen_word.last)
                begin
                    $error("last: expected %0d actual %0d", seen_word.last, last);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        int n_dir;
        int n_rand;
        int phase;

        // terminator right after reset, ch ignored
        add_row(8'hFF, 1'b1, 1, mk_word(KIND_LINE_DONE, 8'h00, STATUS_OK, 1'b1), '0);
        add_row(8'h00, 1'b0, 1, mk_word(KIND_BYTE, 8'h00, STATUS_OK, 1'b1), '0);
        add_row(8'hFF, 1'b0, 1, mk_word(KIND_BYTE, 8'hFF, STATUS_OK, 1'b1), '0);
        add_row(CH_SPACE, 1'b0, 1, mk_word(KIND_ARG_END, 8'h00, STATUS_OK, 1'b1), '0);
        add_row(CH_TAB, 1'b0, 0, '0, '0);
        // double quotes holding blanks and a nested single-quoted span
        push_ch(CH_DQUOTE);
        push_ch(CH_SPACE);
        push_ch(CH_SQUOTE);
        push_ch(CH_DQUOTE);
        push_ch(CH_TAB);
        push_ch(CH_SQUOTE);
        push_ch(CH_DQUOTE);
        // escapes
        push_ch(CH_BSLASH);
        push_ch(CH_LOW_N);
        push_ch(CH_BSLASH);
        push_ch(CH_LOW_T);
        push_ch(CH_BSLASH);
        push_ch(CH_LOW_R);
        add_row(8'h00, 1'b1, 2, mk_word(KIND_ARG_END, 8'h00, STATUS_OK, 1'b0),
                mk_word(KIND_LINE_DONE, 8'h00, STATUS_OK, 1'b1));
        // dangling escape, escape with quote open, unclosed quote
        add_row(CH_BSLASH, 1'b0, 0, '0, '0);
        add_row(8'hFF, 1'b1, 1, mk_word(KIND_LINE_DONE, 8'h00, STATUS_ESCAPE, 1'b1), '0);
        add_row(CH_DQUOTE, 1'b0, 0, '0, '0);
        add_row(CH_BSLASH, 1'b0, 0, '0, '0);
        add_row(8'h00, 1'b1, 1, mk_word(KIND_LINE_DONE, 8'h00, STATUS_ESCAPE, 1'b1), '0);
        add_row(CH_SQUOTE, 1'b0, 0, '0, '0);
        add_row(8'h00, 1'b1, 1, mk_word(KIND_LINE_DONE, 8'h00, STATUS_UNCLOSED, 1'b1), '0);

        n_dir = stim_rows.size();
        while (stim_rows.size() < n_dir + RANDOM_ITEMS)
        begin
            add_line();
        end
        n_rand = stim_rows.size() - n_dir;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < stim_rows.size(); i++)
        begin
            phase = (i < n_dir) ? 0 : ((i - n_dir) * 4) / n_rand;
            case (phase)
                0:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 87;
                    snk_idle_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 87;
                end
                default:
                begin
                    src_idle_pct = 37;
                    snk_idle_pct = 37;
                end
            endcase
            drive_row(stim_rows[i]);
        end
        item_valid <= 1'b0;

        while (token_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
